// ===== design/afd_pkg.sv =====
// ----------------------------------------------------------------------------
// afd_pkg
// shared types and constants for the addressed frame deframer
// ----------------------------------------------------------------------------
`default_nettype none

package afd_pkg;

    localparam int unsigned BYTE_W = 8;

    // configuration register indexes
    localparam logic CFG_SYNC_BYTE   = 1'b0;
    localparam logic CFG_OWN_ADDRESS = 1'b1;

    // configuration reset values
    localparam logic [BYTE_W-1:0] SYNC_BYTE_RST   = 8'd126;
    localparam logic [BYTE_W-1:0] OWN_ADDRESS_RST = 8'd1;

    // one result item
    typedef struct packed {
        logic              data_valid;
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] data_index;
        logic              frame_end;
        logic              frame_good;
    } result_t;

endpackage

`default_nettype wire

// ===== design/afd_core.sv =====
// ----------------------------------------------------------------------------
// afd_core
// frame state machine: one received byte in, one result item out per accept
// ----------------------------------------------------------------------------
`default_nettype none

module afd_core
    import afd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [BYTE_W-1:0] rx_byte,
    input  wire logic [BYTE_W-1:0] sync_byte,
    input  wire logic [BYTE_W-1:0] own_address,
    output result_t                result
);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_ADDR,
        PH_LEN,
        PH_READ,
        PH_CHECK
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] bytes_left_reg, bytes_left_next;
    logic [BYTE_W-1:0] xor_reg, xor_next;
    logic [BYTE_W-1:0] wpos_reg, wpos_next;

    always_comb
    begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        xor_next        = xor_reg;
        wpos_next       = wpos_reg;
        result          = '0;
        case (phase_reg)
            PH_ADDR:
            begin
                phase_next = (rx_byte == own_address) ? PH_LEN : PH_HUNT;
            end
            PH_LEN:
            begin
                bytes_left_next = rx_byte;
                xor_next        = '0;
                wpos_next       = '0;
                phase_next      = (rx_byte != '0) ? PH_READ : PH_HUNT;
            end
            PH_READ:
            begin
                xor_next          = xor_reg ^ rx_byte;
                result.data_valid = 1'b1;
                result.data_byte  = rx_byte;
                result.data_index = wpos_reg;
                wpos_next         = wpos_reg + 1'b1;
                bytes_left_next   = bytes_left_reg - 1'b1;
                // last payload byte when one was left
                phase_next = (bytes_left_reg == BYTE_W'(1)) ? PH_CHECK : PH_READ;
            end
            PH_CHECK:
            begin
                result.frame_end  = 1'b1;
                result.frame_good = (xor_reg == rx_byte);
                phase_next        = PH_HUNT;
            end
            default:
            begin
                phase_next = (rx_byte == sync_byte) ? PH_ADDR : PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            bytes_left_reg <= '0;
            xor_reg        <= '0;
            wpos_reg       <= '0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            xor_reg        <= xor_next;
            wpos_reg       <= wpos_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/afd_out_buf.sv =====
// ----------------------------------------------------------------------------
// afd_out_buf
// result register with a skid stage so input stall is purely registered
// ----------------------------------------------------------------------------
`default_nettype none

module afd_out_buf
    import afd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         full,
    output logic         out_valid,
    input  wire logic    out_stall,
    output result_t      out_data
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_reg;
    result_t skid_reg;
    logic    take;

    assign take      = out_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || take)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || take)
            begin
                out_reg <= push_data;
            end
            else
            begin
                skid_reg <= push_data;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/addressed_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// addressed_frame_deframer
// sync / address / length framed byte receiver with xor checksum check
// ----------------------------------------------------------------------------
// Takes one received byte per item and returns exactly one result item per
// byte. The receiver hunts for sync_byte, then needs own_address, then a
// length byte (1 to 255; zero drops back to hunting). That many payload bytes
// come out with data_valid set and their index in the frame; the next byte is
// the checksum, compared with the xor of the payload, and comes out with
// frame_end set and frame_good telling whether it matched. Other bytes give an
// all-zero result. Throughput is one byte per clock while in_stall is low. The
// frame state is updated in the accepting cycle and the result lands in an
// output register backed by a one-entry skid stage, so in_stall is a flop and
// rises only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module addressed_frame_deframer
    import afd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration write port
    input  wire logic              cfg_write,
    input  wire logic              cfg_index,
    input  wire logic [BYTE_W-1:0] cfg_data,
    // byte input channel
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [BYTE_W-1:0] rx_byte,
    // result channel
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   data_valid,
    output logic [BYTE_W-1:0]      data_byte,
    output logic [BYTE_W-1:0]      data_index,
    output logic                   frame_end,
    output logic                   frame_good
);

    logic [BYTE_W-1:0] sync_byte_reg;
    logic [BYTE_W-1:0] own_address_reg;
    logic              accept;
    logic              buf_full;
    result_t           step_result;
    result_t           out_data;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_byte_reg   <= SYNC_BYTE_RST;
            own_address_reg <= OWN_ADDRESS_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SYNC_BYTE:   sync_byte_reg   <= cfg_data;
                CFG_OWN_ADDRESS: own_address_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // input is taken whenever the skid stage is empty
    assign in_stall = buf_full;
    assign accept   = in_valid && !buf_full;

    afd_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .rx_byte     (rx_byte),
        .sync_byte   (sync_byte_reg),
        .own_address (own_address_reg),
        .result      (step_result)
    );

    afd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (step_result),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // unpack result onto the output ports
    assign data_valid = out_data.data_valid;
    assign data_byte  = out_data.data_byte;
    assign data_index = out_data.data_index;
    assign frame_end  = out_data.frame_end;
    assign frame_good = out_data.frame_good;

`ifndef SYNTHESIS
    // an accepted byte always has a result waiting on the next cycle
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted byte produced no result");

    // skid stage only fills behind a held result
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        buf_full |-> out_valid)
        else $error("skid stage full with empty output register");

    // a byte is payload or checksum, never both
    a_payload_or_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(data_valid && frame_end))
        else $error("payload and frame end in one result");

    // good only on a frame end
    a_good_needs_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_good) |-> frame_end)
        else $error("frame_good without frame_end");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the addressed frame deframer
// ----------------------------------------------------------------------------
// Bytes are pushed through the input channel one item at a time. Each accepted
// byte is run through a cycle-free software copy of the receiver state machine
// (hunt / address / length / payload / checksum), and the result it predicts
// is queued. Every result item the block hands over is checked field by field
// against the oldest prediction. The run starts with hand-picked byte streams
// that hit the corner cases. Register writes then cover the value extremes,
// sync equal to address, and an address change between a sync byte and its
// address. Last comes a long random stretch of frames, mostly well formed,
// under changing register values and three sender/receiver idle profiles.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top
    import afd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // receiver phases as the bench tracks them
    typedef enum logic [2:0] {
        RX_HUNT,
        RX_ADDRESS,
        RX_LENGTH,
        RX_PAYLOAD,
        RX_CHECKSUM
    } rx_phase_t;

    // ------------------------------------------------------------------------
    // clock, reset and block i/o
    // ------------------------------------------------------------------------
    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_write = 1'b0;
    logic              cfg_index = CFG_SYNC_BYTE;
    logic [BYTE_W-1:0] cfg_data  = '0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    logic [BYTE_W-1:0] rx_byte   = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              data_valid;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] data_index;
    logic              frame_end;
    logic              frame_good;

    // 2 ns period
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    addressed_frame_deframer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .data_valid (data_valid),
        .data_byte  (data_byte),
        .data_index (data_index),
        .frame_end  (frame_end),
        .frame_good (frame_good)
    );

    // ------------------------------------------------------------------------
    // bench-side copy of the receiver state and its registers
    // ------------------------------------------------------------------------
    rx_phase_t         frame_phase   = RX_HUNT;
    logic [BYTE_W-1:0] bytes_to_go   = '0;
    logic [BYTE_W-1:0] payload_xor   = '0;
    logic [BYTE_W-1:0] next_index    = '0;
    logic [BYTE_W-1:0] cur_sync      = SYNC_BYTE_RST;
    logic [BYTE_W-1:0] cur_address   = OWN_ADDRESS_RST;

    // predicted result items, oldest first
    result_t           pending_results[$];

    // idle percentages for each side, changed between traffic profiles
    int unsigned       send_idle_pct = 0;
    int unsigned       recv_idle_pct = 0;

    // bookkeeping for the closing summary
    int unsigned       mismatches    = 0;
    int unsigned       bytes_sent    = 0;
    int unsigned       results_seen  = 0;
    int unsigned       payload_seen  = 0;
    int unsigned       good_frames   = 0;
    int unsigned       bad_frames    = 0;
    int unsigned       reg_writes    = 0;

    // advance the receiver by one byte and return the result it gives
    function automatic result_t deframe_byte(input logic [BYTE_W-1:0] b);
        result_t r;
        r = '0;
        case (frame_phase)
            RX_ADDRESS:
            begin
                // anything but our address, sync included, restarts the hunt
                frame_phase = (b == cur_address) ? RX_LENGTH : RX_HUNT;
            end
            RX_LENGTH:
            begin
                bytes_to_go = b;
                payload_xor = '0;
                next_index  = '0;
                // zero length falls straight back to hunting
                frame_phase = (b != '0) ? RX_PAYLOAD : RX_HUNT;
            end
            RX_PAYLOAD:
            begin
                payload_xor  = payload_xor ^ b;
                r.data_valid = 1'b1;
                r.data_byte  = b;
                r.data_index = next_index;
                next_index   = next_index + 8'd1;
                bytes_to_go  = bytes_to_go - 8'd1;
                if (bytes_to_go == '0)
                begin
                    frame_phase = RX_CHECKSUM;
                end
            end
            RX_CHECKSUM:
            begin
                r.frame_end = 1'b1;
                r.frame_good = (payload_xor == b);
                frame_phase = RX_HUNT;
            end
            default:
            begin
                // non-sync bytes while hunting are dropped
                frame_phase = (b == cur_sync) ? RX_ADDRESS : RX_HUNT;
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // result side: random stall and the checker
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    task automatic compare_field(input string name, input logic [BYTE_W-1:0] want,
                                 input logic [BYTE_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected 0x%02h, actual 0x%02h",
                     $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t ns: unexpected result item, expected none, actual %p",
                         $time, {data_valid, data_byte, data_index, frame_end, frame_good});
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("data_valid", 8'(want.data_valid), 8'(data_valid));
                compare_field("data_byte",  want.data_byte,      data_byte);
                compare_field("data_index", want.data_index,     data_index);
                compare_field("frame_end",  8'(want.frame_end),  8'(frame_end));
                compare_field("frame_good", 8'(want.frame_good), 8'(frame_good));
            end
        end
    end

    // ------------------------------------------------------------------------
    // shared stimulus tasks
    // ------------------------------------------------------------------------

    // offer one byte, possibly after a random gap, and predict its result
    // once it is taken; valid is left high so a following item can go back to back
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        result_t want;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        want = deframe_byte(b);
        pending_results.push_back(want);
        bytes_sent++;
        if (want.data_valid)
        begin
            payload_seen++;
        end
        if (want.frame_end)
        begin
            if (want.frame_good)
            begin
                good_frames++;
            end
            else
            begin
                bad_frames++;
            end
        end
    endtask

    // stop offering items and let every predicted result come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        // margin after the last result is checked
        repeat (3) @(posedge clk);
    endtask

    // register write, only with the pipe empty
    task automatic write_reg(input logic idx, input logic [BYTE_W-1:0] value);
        wait_drained();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_SYNC_BYTE)
        begin
            cur_sync = value;
        end
        else
        begin
            cur_address = value;
        end
        reg_writes++;
    endtask

    // sync, address, length, random payload and checksum; a corrupt frame
    // gets a checksum that is guaranteed wrong
    task automatic send_frame(input logic [BYTE_W-1:0] addr, input int unsigned len,
                              input bit corrupt);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] b;
        sum = '0;
        send_byte(cur_sync);
        send_byte(addr);
        send_byte(8'(len));
        if (len != 0)
        begin
            repeat (len)
            begin
                b = 8'($urandom);
                sum = sum ^ b;
                send_byte(b);
            end
            send_byte(corrupt ? (sum ^ 8'($urandom_range(1, 255))) : sum);
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset register values: good and bad checksums, payload extremes,
    // zero length, wrong address (sync value included) and hunting noise
    task automatic test_default_framing();
        logic [BYTE_W-1:0] stream[];
        stream = '{
            8'h00, 8'hFF,                          // noise while hunting
            8'h7E, 8'h01, 8'h01, 8'h00, 8'h00,     // one zero byte, good
            8'h7E, 8'h01, 8'h02, 8'hFF, 8'h80, 8'h7F,
            8'h7E, 8'h01, 8'h01, 8'hAA, 8'h55,     // bad checksum
            8'h7E, 8'h01, 8'h00,                   // zero length
            8'h7E, 8'h7E, 8'h01,                   // sync where address belongs
            8'h7E, 8'h02                           // someone else's frame
        };
        foreach (stream[i])
        begin
            send_byte(stream[i]);
        end
    endtask

    // register value extremes, sync equal to address, and an address
    // change that lands between a sync byte and its address byte
    task automatic test_register_extremes();
        logic [BYTE_W-1:0] low_high[];
        logic [BYTE_W-1:0] high_low[];
        logic [BYTE_W-1:0] same_val[];
        logic [BYTE_W-1:0] late_addr[];
        low_high  = '{8'h7E, 8'h00, 8'hFF, 8'h01, 8'hFF, 8'hFF};
        high_low  = '{8'hFF, 8'h00, 8'h02, 8'h00, 8'h01, 8'h00,
                      8'hFF, 8'h00, 8'h01, 8'hFF, 8'hFF};
        same_val  = '{8'h5A, 8'h5A, 8'h01, 8'h5A, 8'h5A, 8'h5A, 8'h5B};
        late_addr = '{8'h33, 8'h01, 8'hC3, 8'hC3};

        write_reg(CFG_SYNC_BYTE, 8'h00);
        write_reg(CFG_OWN_ADDRESS, 8'hFF);
        foreach (low_high[i])
        begin
            send_byte(low_high[i]);
        end

        write_reg(CFG_SYNC_BYTE, 8'hFF);
        write_reg(CFG_OWN_ADDRESS, 8'h00);
        foreach (high_low[i])
        begin
            send_byte(high_low[i]);
        end

        write_reg(CFG_SYNC_BYTE, 8'h5A);
        write_reg(CFG_OWN_ADDRESS, 8'h5A);
        foreach (same_val[i])
        begin
            send_byte(same_val[i]);
        end

        // the receiver is waiting for an address when the register moves
        send_byte(8'h5A);
        write_reg(CFG_OWN_ADDRESS, 8'h33);
        foreach (late_addr[i])
        begin
            send_byte(late_addr[i]);
        end
    endtask

    // random register values, then random traffic that is mostly well formed
    task automatic test_random_traffic(input int unsigned item_count, input bit with_longest);
        int unsigned stop_at;
        int unsigned roll;
        int unsigned len;
        logic [BYTE_W-1:0] addr;

        write_reg(CFG_SYNC_BYTE, 8'($urandom_range(0, 255)));
        write_reg(CFG_OWN_ADDRESS, 8'($urandom_range(0, 255)));
        stop_at = bytes_sent + item_count;

        // one full-length frame reaches the top payload index
        if (with_longest)
        begin
            send_frame(cur_address, 255, 1'b0);
        end

        while (bytes_sent < stop_at)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
            begin
                // own frame, mostly short, now and then long
                len = ($urandom_range(0, 79) == 0) ? $urandom_range(128, 255)
                                                   : $urandom_range(1, 12);
                send_frame(cur_address, len, $urandom_range(0, 4) == 0);
            end
            else if (roll < 80)
            begin
                // frame for another station; sometimes the sync value as address
                addr = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 3) == 0)
                begin
                    addr = cur_sync;
                end
                if (addr == cur_address)
                begin
                    addr = cur_address + 8'd1;
                end
                send_frame(addr, $urandom_range(1, 6), 1'b0);
            end
            else if (roll < 85)
            begin
                send_frame(cur_address, 0, 1'b0);
            end
            else
            begin
                // line noise
                repeat ($urandom_range(1, 6))
                begin
                    send_byte(8'($urandom));
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // run sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender idles a little, receiver a lot
        send_idle_pct = 13;
        recv_idle_pct = 59;
        test_default_framing();
        test_register_extremes();
        test_random_traffic(250, 1'b1);
        test_random_traffic(250, 1'b0);

        // the other way round
        send_idle_pct = 59;
        recv_idle_pct = 13;
        test_random_traffic(250, 1'b1);
        test_random_traffic(250, 1'b0);

        // full rate both ways
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(250, 1'b1);
        test_random_traffic(250, 1'b0);

        wait_drained();
        repeat (10) @(posedge clk);

        $display("sent %0d bytes under %0d register writes, checked %0d results",
                 bytes_sent, reg_writes, results_seen);
        $display("payload bytes %0d, good frames %0d, bad-checksum frames %0d",
                 payload_seen, good_frames, bad_frames);
        if (mismatches == 0 && pending_results.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin
        #1_000_000;
        $display("timeout with %0d results still pending", pending_results.size());
        $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
